@@ rtl/ddl_pkg.sv @@
// Package: shared types and constants of the discrete distribution lookup unit.
package ddl_pkg;

	// Q1.16 probability of one
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPORT_SIZE = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_CDF      = 2'd1,
		OP_PDF      = 2'd2,
		OP_QUANTILE = 2'd3
	} op_t;

	// One stored entry: point, weight and cumulative sum
	typedef struct packed {
		logic signed [31:0] point;
		logic [16:0]        weight;
		logic [16:0]        cum;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAIT,
		ST_LOAD,
		ST_C_LAST,
		ST_C_FIRST,
		ST_P_LAST,
		ST_P_FIRST,
		ST_BIS,
		ST_BIS_EVAL,
		ST_C_UP,
		ST_C_CUM,
		ST_P_UP,
		ST_P_DN,
		ST_Q_EVAL,
		ST_DONE
	} state_t;

endpackage

@@ rtl/ddl_if.sv @@
// Interfaces: request and response channels of the discrete distribution lookup unit.
interface ddl_req_if;
	logic               valid;
	logic               ready;
	ddl_pkg::op_t       op;
	logic [7:0]         slot;
	logic signed [31:0] coord;
	logic [16:0]        prob_in;
	logic               tail;

	modport source (output valid, op, slot, coord, prob_in, tail, input ready);
	modport sink (input valid, op, slot, coord, prob_in, tail, output ready);
endinterface

interface ddl_rsp_if;
	logic               valid;
	logic               ready;
	logic [16:0]        prob_out;
	logic signed [31:0] point_out;
	logic               status;

	modport source (output valid, prob_out, point_out, status, input ready);
	modport sink (input valid, prob_out, point_out, status, output ready);
endinterface

@@ rtl/discrete_distribution_lookup_unit.sv @@
// A load writes one entry; a CDF query bisects over the active support and reads one
// cumulative value; a PDF query bisects and then sums the entries near x; a quantile
// query scans the entries from index 0 upward (n = active support size).
// One item is in flight at a time; the single read port of the entry memory (registered
// read, with ST_WAIT before each read result is used) sets the pace. Reset clears the control
// state and running sum, sets tolerance and support size to 1; the memory is not cleared.
module discrete_distribution_lookup_unit #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ddl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_wdata,
	ddl_req_if.sink                        req,
	ddl_rsp_if.source                      rsp
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = (IW + 1 > 9) ? IW + 1 : 9;

	typedef logic [CW-1:0] idx_t;

	// Point comparisons with tolerance, on a 33-bit difference
	function automatic logic signed [32:0] pdiff(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		return d;
	endfunction

	function automatic logic beyond(logic signed [31:0] a, logic signed [31:0] b,
			logic [15:0] eps);
		return pdiff(a, b) > $signed({17'd0, eps});
	endfunction

	function automatic logic reaches(logic signed [31:0] a, logic signed [31:0] b,
			logic [15:0] eps);
		return pdiff(a, b) >= $signed({17'd0, eps});
	endfunction

	function automatic logic near(logic signed [31:0] a, logic signed [31:0] b,
			logic [15:0] eps);
		logic signed [32:0] d;
		logic signed [32:0] e;
		d = pdiff(a, b);
		e = $signed({17'd0, eps});
		return (d <= e) && (d >= ($signed(33'd0) - e));
	endfunction

	// Configuration
	logic [15:0] tol_q;
	logic [8:0]  size_q;

	// Control state
	ddl_pkg::state_t state_q, state_d, ret_q, ret_d;
	idx_t            addr_q, addr_d, lo_q, lo_d, hi_q, hi_d;
	logic [16:0]     sum_q, sum_d, rs_q, rs_d;
	logic            out_valid_q, out_valid_d;

	// Item and result holding registers
	ddl_pkg::op_t       op_q;
	logic [7:0]         slot_q;
	logic signed [31:0] x_q;
	logic [16:0]        prob_q;
	logic               tail_q;
	idx_t               n_q;
	logic [16:0]        res_prob_q, res_prob_d;
	logic signed [31:0] res_point_q, res_point_d;
	logic               res_status_q, res_status_d;
	logic [16:0]        out_prob_q;
	logic signed [31:0] out_point_q;
	logic               out_status_q;

	// Entry memory
	ddl_pkg::entry_t entry_mem [MAX_ENTRIES];
	ddl_pkg::entry_t rd_data_q;
	ddl_pkg::entry_t wr_data;
	logic            mem_we;
	logic            in_ready;
	logic            accept;
	logic            out_load;

	idx_t        size_ext, n_now, slot_ext, pick;
	logic [CW:0] mid_full;
	logic [17:0] sum_add, load_add;
	logic [16:0] sum_sat, load_sat, target;

	assign accept   = req.valid && in_ready;
	assign size_ext = CW'(size_q);
	assign n_now    = (size_ext == '0) ? CW'(1) :
	                  (size_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : size_ext;
	assign slot_ext = CW'(slot_q);
	assign mid_full = {1'b0, lo_q} + {1'b0, hi_q};

	// Saturating sums for the PDF accumulation and the running sum
	assign sum_add  = {1'b0, sum_q} + {1'b0, rd_data_q.weight};
	assign sum_sat  = (sum_add > {1'b0, ddl_pkg::ONE_Q16}) ? ddl_pkg::ONE_Q16 : sum_add[16:0];
	assign load_add = ((slot_q == 8'd0) ? 18'd0 : {1'b0, rs_q}) + {1'b0, prob_q};
	assign load_sat = (load_add > {1'b0, ddl_pkg::ONE_Q16}) ? ddl_pkg::ONE_Q16 : load_add[16:0];
	assign target   = tail_q ? (ddl_pkg::ONE_Q16 - prob_q) : prob_q;

	assign wr_data.point  = x_q;
	assign wr_data.weight = prob_q;
	assign wr_data.cum    = load_sat;

	assign req.ready     = in_ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.prob_out  = out_prob_q;
	assign rsp.point_out = out_point_q;
	assign rsp.status    = out_status_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= 16'd1;
			size_q <= 9'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ddl_pkg::REG_TOLERANCE: begin
					tol_q <= cfg_wdata;
				end
				ddl_pkg::REG_SUPPORT_SIZE: begin
					size_q <= cfg_wdata[8:0];
				end
			endcase
		end
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[slot_ext[IW-1:0]] <= wr_data;
		end
		rd_data_q <= entry_mem[addr_q[IW-1:0]];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddl_pkg::ST_IDLE;
			ret_q       <= ddl_pkg::ST_IDLE;
			addr_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			sum_q       <= '0;
			rs_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			addr_q      <= addr_d;
			lo_q        <= lo_d;
			hi_q        <= hi_d;
			sum_q       <= sum_d;
			rs_q        <= rs_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Capture the item, hold results, load the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.op;
			slot_q <= req.slot;
			x_q    <= req.coord;
			prob_q <= (req.prob_in > ddl_pkg::ONE_Q16) ? ddl_pkg::ONE_Q16 : req.prob_in;
			tail_q <= req.tail;
			n_q    <= n_now;
		end
		res_prob_q   <= res_prob_d;
		res_point_q  <= res_point_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_prob_q   <= res_prob_q;
			out_point_q  <= res_point_q;
			out_status_q <= res_status_q;
		end
	end

	// Sequencer: next state, memory addresses and results
	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		addr_d       = addr_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		sum_d        = sum_q;
		rs_d         = rs_q;
		res_prob_d   = res_prob_q;
		res_point_d  = res_point_q;
		res_status_d = res_status_q;
		out_valid_d  = out_valid_q;
		out_load     = 1'b0;
		mem_we       = 1'b0;
		in_ready     = 1'b0;
		pick         = reaches(rd_data_q.point, x_q, tol_q) ? lo_q : hi_q;

		// Drop the output once taken
		if (out_valid_q && rsp.ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			ddl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					res_prob_d   = '0;
					res_point_d  = '0;
					res_status_d = 1'b0;
					sum_d        = '0;
					unique case (req.op)
						ddl_pkg::OP_LOAD: begin
							state_d = ddl_pkg::ST_LOAD;
						end
						ddl_pkg::OP_CDF: begin
							addr_d  = n_now - CW'(1);
							ret_d   = ddl_pkg::ST_C_LAST;
							state_d = ddl_pkg::ST_WAIT;
						end
						ddl_pkg::OP_PDF: begin
							addr_d  = n_now - CW'(1);
							ret_d   = ddl_pkg::ST_P_LAST;
							state_d = ddl_pkg::ST_WAIT;
						end
						ddl_pkg::OP_QUANTILE: begin
							addr_d  = '0;
							ret_d   = ddl_pkg::ST_Q_EVAL;
							state_d = ddl_pkg::ST_WAIT;
						end
					endcase
				end
			end
			ddl_pkg::ST_WAIT: begin
				state_d = ret_q;
			end
			ddl_pkg::ST_LOAD: begin
				if (slot_ext >= n_q) begin
					res_status_d = 1'b1;
				end else begin
					mem_we     = 1'b1;
					rs_d       = load_sat;
					res_prob_d = load_sat;
				end
				state_d = ddl_pkg::ST_DONE;
			end
			ddl_pkg::ST_C_LAST: begin
				if (!reaches(rd_data_q.point, x_q, tol_q)) begin
					res_prob_d = ddl_pkg::ONE_Q16;
					state_d    = ddl_pkg::ST_DONE;
				end else begin
					addr_d  = '0;
					ret_d   = ddl_pkg::ST_C_FIRST;
					state_d = ddl_pkg::ST_WAIT;
				end
			end
			ddl_pkg::ST_C_FIRST: begin
				if (reaches(rd_data_q.point, x_q, tol_q)) begin
					state_d = ddl_pkg::ST_DONE;
				end else begin
					lo_d    = '0;
					hi_d    = n_q - CW'(1);
					state_d = ddl_pkg::ST_BIS;
				end
			end
			ddl_pkg::ST_P_LAST: begin
				if (beyond(x_q, rd_data_q.point, tol_q)) begin
					state_d = ddl_pkg::ST_DONE;
				end else begin
					addr_d  = '0;
					ret_d   = ddl_pkg::ST_P_FIRST;
					state_d = ddl_pkg::ST_WAIT;
				end
			end
			ddl_pkg::ST_P_FIRST: begin
				if (beyond(rd_data_q.point, x_q, tol_q)) begin
					state_d = ddl_pkg::ST_DONE;
				end else begin
					lo_d    = '0;
					hi_d    = n_q - CW'(1);
					state_d = ddl_pkg::ST_BIS;
				end
			end
			ddl_pkg::ST_BIS: begin
				// Probe the midpoint until the bracket is one entry wide
				if ((hi_q - lo_q) > CW'(1)) begin
					addr_d = mid_full[CW:1];
					ret_d  = ddl_pkg::ST_BIS_EVAL;
				end else begin
					addr_d = hi_q;
					ret_d  = (op_q == ddl_pkg::OP_CDF) ? ddl_pkg::ST_C_UP : ddl_pkg::ST_P_UP;
				end
				state_d = ddl_pkg::ST_WAIT;
			end
			ddl_pkg::ST_BIS_EVAL: begin
				if (beyond(rd_data_q.point, x_q, tol_q)) begin
					hi_d = addr_q;
				end else begin
					lo_d = addr_q;
				end
				state_d = ddl_pkg::ST_BIS;
			end
			ddl_pkg::ST_C_UP: begin
				// Last entry counts as full
				if (pick == n_q - CW'(1)) begin
					res_prob_d = ddl_pkg::ONE_Q16;
					state_d    = ddl_pkg::ST_DONE;
				end else begin
					addr_d  = pick;
					ret_d   = ddl_pkg::ST_C_CUM;
					state_d = ddl_pkg::ST_WAIT;
				end
			end
			ddl_pkg::ST_C_CUM: begin
				res_prob_d = rd_data_q.cum;
				state_d    = ddl_pkg::ST_DONE;
			end
			ddl_pkg::ST_P_UP: begin
				// Scan upward from the upper bracket, then downward below it
				if (near(x_q, rd_data_q.point, tol_q)
						&& ((addr_q + CW'(1)) < n_q)) begin
					sum_d   = sum_sat;
					addr_d  = addr_q + CW'(1);
					ret_d   = ddl_pkg::ST_P_UP;
					state_d = ddl_pkg::ST_WAIT;
				end else begin
					if (near(x_q, rd_data_q.point, tol_q)) begin
						sum_d = sum_sat;
					end
					if (hi_q != '0) begin
						addr_d  = hi_q - CW'(1);
						ret_d   = ddl_pkg::ST_P_DN;
						state_d = ddl_pkg::ST_WAIT;
					end else begin
						res_prob_d = sum_d;
						state_d    = ddl_pkg::ST_DONE;
					end
				end
			end
			ddl_pkg::ST_P_DN: begin
				if (near(x_q, rd_data_q.point, tol_q)) begin
					sum_d = sum_sat;
					if (addr_q != '0) begin
						addr_d  = addr_q - CW'(1);
						ret_d   = ddl_pkg::ST_P_DN;
						state_d = ddl_pkg::ST_WAIT;
					end else begin
						res_prob_d = sum_sat;
						state_d    = ddl_pkg::ST_DONE;
					end
				end else begin
					res_prob_d = sum_q;
					state_d    = ddl_pkg::ST_DONE;
				end
			end
			ddl_pkg::ST_Q_EVAL: begin
				// Advance while the cumulative value is below the target
				if (((addr_q + CW'(1)) < n_q) && (rd_data_q.cum < target)) begin
					addr_d  = addr_q + CW'(1);
					ret_d   = ddl_pkg::ST_Q_EVAL;
					state_d = ddl_pkg::ST_WAIT;
				end else begin
					res_point_d = rd_data_q.point;
					state_d     = ddl_pkg::ST_DONE;
				end
			end
			ddl_pkg::ST_DONE: begin
				// Hold until the output register is free
				if (!out_valid_q || rsp.ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ddl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ddl_pkg::ST_IDLE;
			end
		endcase
	end

	// Running sum and PDF sum never pass one
	assert property (@(posedge clk) disable iff (!arst_n)
		(rs_q <= ddl_pkg::ONE_Q16) && (sum_q <= ddl_pkg::ONE_Q16))
		else $error("probability sum above one");

	// Bisection bracket stays ordered and inside the support
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddl_pkg::ST_BIS) |-> ((lo_q <= hi_q) && (hi_q < n_q)))
		else $error("bisection bracket out of range");

	// Every memory read stays inside the active support
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ddl_pkg::ST_WAIT) |-> (addr_q < n_q))
		else $error("read address beyond support size");

	// A refused load reports no probability
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status) |-> (rsp.prob_out == '0))
		else $error("refused load with nonzero probability");

	// A new result is loaded only when the previous transaction has left
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("output overwritten before transfer");

endmodule

@@ verif/discrete_distribution_lookup_unit_tb.sv @@
// Testbench: self-checking stimulus and prediction for the discrete distribution lookup unit.
module discrete_distribution_lookup_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ddl_pkg::*;

	localparam int unsigned MAX_ENTRIES  = 256;
	localparam int unsigned RANDOM_ITEMS = 1000;
	localparam int unsigned IDLE_PCT     = 38;
	localparam int unsigned STEADY_FROM  = 350;
	localparam int unsigned STEADY_TO    = 500;
	localparam int unsigned DRAIN_CYCLES = 600;
	localparam longint      LIMIT_CYCLES = 4000000;
	localparam longint      PT_MAX       = 64'sd2147483647;
	localparam longint      PT_MIN       = -64'sd2147483648;

	typedef struct packed {
		op_t                op;
		logic [7:0]         slot;
		logic signed [31:0] coord;
		logic [16:0]        prob_in;
		logic               tail;
	} lookup_req_t;

	typedef struct packed {
		logic [16:0]        prob_out;
		logic signed [31:0] point_out;
		logic               status;
	} lookup_rsp_t;

	typedef struct {
		bit          fixed;
		lookup_rsp_t rsp;
	} answer_key_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [15:0]           reg_val;
		lookup_req_t           item;
		bit                    fixed;
		lookup_rsp_t           answer;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_wdata;

	ddl_req_if req_ch ();
	ddl_rsp_if rsp_ch ();

	discrete_distribution_lookup_unit #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// Predictor copy of the distribution table and its registers
	longint      pt_mem   [MAX_ENTRIES];
	int unsigned wt_mem   [MAX_ENTRIES];
	int unsigned cum_mem  [MAX_ENTRIES];
	int unsigned run_sum  = 0;
	int unsigned tol_reg  = 1;
	int unsigned size_reg = 1;

	// Stimulus-side view of what has been loaded
	bit                 loaded    [MAX_ENTRIES];
	logic signed [31:0] stored_pt [MAX_ENTRIES];
	int unsigned        stim_n   = 1;
	int unsigned        stim_tol = 1;
	bit                 steady   = 1'b0;

	lookup_rsp_t pending_lookups [$];
	answer_key_t answer_keys     [$];
	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned bad_results  = 0;
	longint      cycle_count  = 0;

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned eff_size(int unsigned raw);
		if (raw == 0) return 1;
		if (raw > MAX_ENTRIES) return MAX_ENTRIES;
		return raw;
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > PT_MAX) return 32'sh7FFFFFFF;
		if (v < PT_MIN) return 32'sh80000000;
		return 32'(v);
	endfunction

	// a - b strictly exceeds the tolerance
	function automatic bit past(longint a, longint b, longint e);
		return (a > b) && ((a - b) > e);
	endfunction

	// a - b reaches the tolerance; plain a >= b when tolerance is zero
	function automatic bit reached(longint a, longint b, longint e);
		if (e == 0) return a >= b;
		return (a > b) && ((a - b) >= e);
	endfunction

	function automatic bit within_tol(longint a, longint b, longint e);
		return !past(a, b, e) && !past(b, a, e);
	endfunction

	// Last entry in use always counts as full probability
	function automatic int unsigned cum_of(int unsigned i, int unsigned n);
		if (i + 1 == n) return ONE_Q16;
		return cum_mem[i];
	endfunction

	// Bisect for x; return the upper bracket index, lower one through lo
	function automatic int unsigned split_at(longint x, longint e, int unsigned n,
		output int unsigned lo);
		int unsigned lower, upper, mid;
		lower = 0;
		upper = n - 1;
		while (upper - lower > 1) begin
			mid = (upper + lower) / 2;
			if (past(pt_mem[mid], x, e))
				upper = mid;
			else
				lower = mid;
		end
		lo = lower;
		return upper;
	endfunction

	// Apply one transaction to the predictor state and return its answer
	function automatic lookup_rsp_t predict_lookup(lookup_req_t it);
		lookup_rsp_t r;
		int unsigned n, lo, up, i, p, w, acc;
		longint x, e;
		r = '0;
		n = eff_size(size_reg);
		x = longint'(it.coord);
		e = longint'(tol_reg);
		w = (it.prob_in > ONE_Q16) ? ONE_Q16 : it.prob_in;
		case (it.op)
			OP_LOAD: begin
				if (it.slot >= n) begin
					r.status = 1'b1;
				end else begin
					if (it.slot == 0) run_sum = 0;
					run_sum += w;
					if (run_sum > ONE_Q16) run_sum = ONE_Q16;
					pt_mem[it.slot]  = x;
					wt_mem[it.slot]  = w;
					cum_mem[it.slot] = run_sum;
					r.prob_out = 17'(run_sum);
				end
			end
			OP_CDF: begin
				if (!reached(pt_mem[n - 1], x, e)) begin
					r.prob_out = ONE_Q16;
				end else if (reached(pt_mem[0], x, e)) begin
					r.prob_out = '0;
				end else begin
					up = split_at(x, e, n, lo);
					r.prob_out = 17'(reached(pt_mem[up], x, e) ? cum_of(lo, n) : cum_of(up, n));
				end
			end
			OP_PDF: begin
				if (past(x, pt_mem[n - 1], e) || past(pt_mem[0], x, e)) begin
					r.prob_out = '0;
				end else begin
					up = split_at(x, e, n, lo);
					acc = 0;
					for (i = up; i < n && within_tol(x, pt_mem[i], e); i++) begin
						acc += wt_mem[i];
						if (acc > ONE_Q16) acc = ONE_Q16;
					end
					for (i = up; i > 0 && within_tol(x, pt_mem[i - 1], e); i--) begin
						acc += wt_mem[i - 1];
						if (acc > ONE_Q16) acc = ONE_Q16;
					end
					r.prob_out = 17'(acc);
				end
			end
			default: begin
				p = it.tail ? (ONE_Q16 - w) : w;
				i = 0;
				while (i + 1 < n && cum_of(i, n) < p) i++;
				r.point_out = 32'(pt_mem[i]);
			end
		endcase
		return r;
	endfunction

	function automatic plan_row_t item_row(op_t op, logic [7:0] slot, logic [31:0] coord,
		logic [16:0] prob, logic tail);
		plan_row_t r;
		r.is_cfg       = 1'b0;
		r.reg_idx      = '0;
		r.reg_val      = '0;
		r.item.op      = op;
		r.item.slot    = slot;
		r.item.coord   = coord;
		r.item.prob_in = prob;
		r.item.tail    = tail;
		r.fixed        = 1'b0;
		r.answer       = '0;
		return r;
	endfunction

	function automatic plan_row_t known_row(op_t op, logic [7:0] slot, logic [31:0] coord,
		logic [16:0] prob, logic tail, logic [16:0] po, logic [31:0] pt, logic st);
		plan_row_t r;
		r = item_row(op, slot, coord, prob, tail);
		r.fixed            = 1'b1;
		r.answer.prob_out  = po;
		r.answer.point_out = pt;
		r.answer.status    = st;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		plan_row_t r;
		r = item_row(OP_LOAD, 8'd0, 32'd0, 17'd0, 1'b0);
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// Drive one transaction on the request channel and hold until it is taken
	task automatic send_item(input lookup_req_t it, input bit fixed, input lookup_rsp_t answer);
		answer_key_t key;
		key.fixed = fixed;
		key.rsp   = answer;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		answer_keys.push_back(key);
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.op      <= it.op;
		req_ch.slot    <= it.slot;
		req_ch.coord   <= it.coord;
		req_ch.prob_in <= it.prob_in;
		req_ch.tail    <= it.tail;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		steady = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
		if (it.op == OP_LOAD && it.slot < stim_n) begin
			loaded[it.slot]    = 1'b1;
			stored_pt[it.slot] = it.coord;
		end
	endtask

	// Drop valid and wait until every answer has come back
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SUPPORT_SIZE)
			stim_n = eff_size(int'(val[8:0]));
		else
			stim_tol = val;
	endtask

	// Response ready with random stalls
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watch both channels and the register port; check answers in order
	always @(posedge clk) begin : watch_ports
		lookup_req_t seen;
		lookup_rsp_t got, want;
		answer_key_t key;
		if (arst_n) begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_TOLERANCE)
					tol_reg = cfg_wdata;
				else
					size_reg = cfg_wdata[8:0];
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				got.prob_out  = rsp_ch.prob_out;
				got.point_out = rsp_ch.point_out;
				got.status    = rsp_ch.status;
				if (pending_lookups.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("unexpected result: prob_out %0h point_out %0h status %0b",
							got.prob_out, got.point_out, got.status);
				end else begin
					want = pending_lookups.pop_front();
					if (got.prob_out !== want.prob_out || got.point_out !== want.point_out ||
						got.status !== want.status) begin
						bad_results++;
						if (bad_results <= 10)
							$display({"mismatch at cycle %0d: prob_out exp %0h got %0h, ",
								"point_out exp %0h got %0h, status exp %0b got %0b"},
								cycle_count, want.prob_out, got.prob_out, want.point_out,
								got.point_out, want.status, got.status);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.op      = req_ch.op;
				seen.slot    = req_ch.slot;
				seen.coord   = req_ch.coord;
				seen.prob_in = req_ch.prob_in;
				seen.tail    = req_ch.tail;
				want = predict_lookup(seen);
				key = answer_keys.pop_front();
				if (key.fixed) want = key.rsp;
				pending_lookups.push_back(want);
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("[discrete_distribution_lookup_unit] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t          rows [$];
		lookup_req_t        it;
		logic signed [31:0] layout [MAX_ENTRIES];
		int unsigned        order  [MAX_ENTRIES];
		int unsigned        random_items, n_eff, roll, style, count, q, k, j, tmp, span;
		int unsigned        size_pick, tol_pick;
		bit                 reload;
		longint             cur;

		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = REG_TOLERANCE;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.op      = OP_LOAD;
		req_ch.slot    = '0;
		req_ch.coord   = '0;
		req_ch.prob_in = '0;
		req_ch.tail    = 1'b0;
		for (k = 0; k < MAX_ENTRIES; k++) begin
			pt_mem[k]    = 0;
			wt_mem[k]    = 0;
			cum_mem[k]   = 0;
			loaded[k]    = 1'b0;
			stored_pt[k] = '0;
		end

		// Hold reset, then release on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table: reset settings, extremes, saturation, refused loads
		rows.push_back(known_row(OP_LOAD, 8'd1, 32'd0, 17'd0, 1'b0, 17'd0, 32'd0, 1'b1));
		rows.push_back(known_row(OP_LOAD, 8'd0, 32'h7FFFFFFF, 17'h1FFFF, 1'b0,
			17'h10000, 32'd0, 1'b0));
		rows.push_back(item_row(OP_CDF, 8'd0, 32'h80000000, 17'd0, 1'b0));
		rows.push_back(item_row(OP_PDF, 8'd0, 32'h7FFFFFFF, 17'd0, 1'b0));
		rows.push_back(known_row(OP_QUANTILE, 8'd0, 32'd0, 17'd0, 1'b1,
			17'd0, 32'h7FFFFFFF, 1'b0));
		rows.push_back(cfg_row(REG_TOLERANCE, 16'd0));
		rows.push_back(cfg_row(REG_SUPPORT_SIZE, 16'd4));
		rows.push_back(known_row(OP_LOAD, 8'd0, 32'h80000000, 17'd0, 1'b0,
			17'd0, 32'd0, 1'b0));
		rows.push_back(item_row(OP_LOAD, 8'd1, 32'hFFFF0000, 17'h04000, 1'b0));
		rows.push_back(item_row(OP_LOAD, 8'd2, 32'h00000000, 17'h08000, 1'b0));
		rows.push_back(item_row(OP_LOAD, 8'd3, 32'h7FFFFFFF, 17'h08000, 1'b1));
		rows.push_back(known_row(OP_LOAD, 8'd255, 32'h00012345, 17'h1FFFF, 1'b1,
			17'd0, 32'd0, 1'b1));
		rows.push_back(item_row(OP_CDF, 8'd0, 32'h00000000, 17'd0, 1'b0));
		rows.push_back(item_row(OP_CDF, 8'd0, 32'h7FFFFFFF, 17'd0, 1'b0));
		rows.push_back(item_row(OP_CDF, 8'd0, 32'h80000000, 17'd0, 1'b0));
		rows.push_back(item_row(OP_PDF, 8'd0, 32'h00000000, 17'd0, 1'b0));
		rows.push_back(item_row(OP_PDF, 8'd0, 32'h80000000, 17'd0, 1'b0));
		rows.push_back(item_row(OP_QUANTILE, 8'd0, 32'd0, 17'h1FFFF, 1'b0));
		rows.push_back(item_row(OP_QUANTILE, 8'd0, 32'd0, 17'h10000, 1'b1));
		rows.push_back(item_row(OP_QUANTILE, 8'd0, 32'd0, 17'h06000, 1'b0));
		rows.push_back(cfg_row(REG_TOLERANCE, 16'hFFFF));
		rows.push_back(item_row(OP_PDF, 8'd0, 32'h00008000, 17'd0, 1'b0));
		rows.push_back(item_row(OP_CDF, 8'd0, 32'hFFFF0001, 17'd0, 1'b0));
		rows.push_back(cfg_row(REG_SUPPORT_SIZE, 16'd0));
		rows.push_back(item_row(OP_CDF, 8'd0, 32'h00000005, 17'd0, 1'b0));
		rows.push_back(item_row(OP_QUANTILE, 8'd0, 32'd0, 17'd0, 1'b0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				settle();
				cfg_write(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				send_item(rows[i].item, rows[i].fixed, rows[i].answer);
			end
		end

		// Random phases: new settings, a table load, then a query mix
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(4))
				0: tol_pick = 0;
				1: tol_pick = 1;
				2: tol_pick = 16'hFFFF;
				3: tol_pick = $urandom_range(255);
				default: tol_pick = $urandom_range(16'hFFFF);
			endcase
			roll = $urandom_range(99);
			if (roll < 4)
				size_pick = 9'h1FF;
			else if (roll < 9)
				size_pick = MAX_ENTRIES;
			else if (roll < 13)
				size_pick = $urandom_range(100, 255);
			else if (roll < 20)
				size_pick = $urandom_range(1);
			else if (roll < 35)
				size_pick = $urandom_range(17, 64);
			else
				size_pick = $urandom_range(2, 16);
			settle();
			cfg_write(REG_TOLERANCE, 16'(tol_pick));
			cfg_write(REG_SUPPORT_SIZE, 16'(size_pick));
			n_eff = stim_n;
			span  = 2 * stim_tol + 2;

			// Reload at random, and always when some entry in use was never written
			reload = ($urandom_range(9) < 7);
			for (k = 0; k < n_eff; k++)
				if (!loaded[k]) reload = 1'b1;

			if (reload) begin
				style = $urandom_range(9);
				cur = ($urandom_range(1) == 0) ?
					longint'($urandom_range(0, 1 << 20)) - (1 << 19) :
					longint'($signed($urandom));
				for (k = 0; k < n_eff; k++) begin
					order[k] = k;
					if (style == 0) begin
						layout[k] = $urandom;
					end else begin
						layout[k] = sat32(cur);
						roll = $urandom_range(9);
						if (roll < 2)
							cur = cur;
						else if (roll < 7)
							cur += $urandom_range(0, span);
						else
							cur += $urandom_range(0, 1 << 22);
					end
				end
				// Shuffle the load order now and then
				if (style == 1) begin
					for (k = n_eff - 1; k > 0; k--) begin
						j = $urandom_range(0, k);
						tmp = order[k];
						order[k] = order[j];
						order[j] = tmp;
					end
				end
				for (k = 0; k < n_eff; k++) begin
					it.op      = OP_LOAD;
					it.slot    = 8'(order[k]);
					it.coord   = layout[order[k]];
					it.prob_in = ($urandom_range(19) == 0) ? 17'($urandom_range(17'h1FFFF)) :
						17'($urandom_range(0, 98304 / n_eff + 1));
					it.tail    = $urandom_range(1);
					send_item(it, 1'b0, '0);
					random_items++;
				end
			end

			count = $urandom_range(10, 60);
			for (q = 0; q < count; q++) begin
				roll = $urandom_range(99);
				k = $urandom_range(0, n_eff - 1);
				it.slot    = $urandom;
				it.prob_in = $urandom_range(17'h1FFFF);
				it.tail    = $urandom_range(1);
				// Query points mostly land near a stored point
				if ($urandom_range(3) == 0)
					it.coord = $urandom;
				else
					it.coord = sat32(longint'(stored_pt[k]) +
						longint'($urandom_range(0, 2 * span)) - longint'(span));
				if (roll < 12) begin
					it.op = OP_LOAD;
					if ($urandom_range(3) != 0)
						it.slot = 8'((n_eff > 255) ? $urandom_range(0, 255) :
							$urandom_range(0, n_eff));
					it.prob_in = ($urandom_range(9) == 0) ? 17'($urandom_range(17'h1FFFF)) :
						17'($urandom_range(0, 98304 / n_eff + 1));
				end else if (roll < 42) begin
					it.op = OP_CDF;
				end else if (roll < 72) begin
					it.op = OP_PDF;
				end else begin
					it.op = OP_QUANTILE;
					if ($urandom_range(9) < 7) it.prob_in = $urandom_range(0, 65536);
				end
				send_item(it, 1'b0, '0);
				random_items++;
			end
		end

		// Drain and let the block go quiet
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_lookups.size() != 0) begin
			bad_results += pending_lookups.size();
			$display("%0d expected results never arrived", pending_lookups.size());
		end
		if (bad_results == 0)
			$display("[discrete_distribution_lookup_unit] OK");
		else
			$display("[discrete_distribution_lookup_unit] ERROR");
		$finish;
	end

endmodule
